### hdl/tcw_pkg.sv
// Shared constants, types and helper functions for the text console writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);

  localparam int OP_W     = 2;
  localparam int CODE_W   = 8;
  localparam int IN_ROW_W = 5;
  localparam int IN_COL_W = 7;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [ATTR_W-1:0] attr_t;
  typedef logic [POS_W-1:0]  pos_t;

  localparam attr_t RESET_ATTR = 8'h0F;

  localparam code_t CH_BS    = 8'h08;
  localparam code_t CH_TAB   = 8'h09;
  localparam code_t CH_LF    = 8'h0A;
  localparam code_t CH_CR    = 8'h0D;
  localparam code_t CH_SPACE = 8'h20;

  localparam int    TAB_STOP   = 8;
  localparam cell_t RESET_CELL = {RESET_ATTR, CH_SPACE};

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FILL,
    ST_SCROLL,
    ST_RESP
  } state_t;

  // Outcome of one put-character step on the cursor.
  typedef struct packed {
    col_t col;
    row_t row;
    logic wr;
    logic scroll;
  } put_res_t;

  function automatic addr_t cell_index(input row_t row, input col_t col);
    return addr_t'(addr_t'(row) * addr_t'(COLUMNS) + addr_t'(col));
  endfunction

endpackage

### hdl/tcw_if.sv
// Valid/ready channel interfaces for requests, results and the attribute register.
interface tcw_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::OP_W-1:0]      operation;
  logic [tcw_pkg::CODE_W-1:0]    char_code;
  logic [tcw_pkg::IN_ROW_W-1:0]  cell_row;
  logic [tcw_pkg::IN_COL_W-1:0]  cell_col;

  modport source (output valid, operation, char_code, cell_row, cell_col, input ready);
  modport sink   (input valid, operation, char_code, cell_row, cell_col, output ready);
endinterface

interface tcw_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::POS_W-1:0]   cursor_pos;
  logic [tcw_pkg::CELL_W-1:0]  cell_data;

  modport source (output valid, cursor_pos, cell_data, input ready);
  modport sink   (input valid, cursor_pos, cell_data, output ready);
endinterface

interface tcw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::ATTR_W-1:0]  text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink   (input valid, text_attribute, output ready);
endinterface

### hdl/text_console_writer.sv
// Top level of the text console writer: sequencer around the cell store.
//
// Requests arrive on in_req (put character, clear screen, read cell) and each
// one produces exactly one result on out_rsp: the linear cursor position after
// the request and, for a read, the 16-bit cell (attribute high, character low).
// cfg_wr sets the attribute byte used for written characters and blanks; it is
// always ready and should only be written while no request is in flight.
// The 80x25 cell store is one RAM with one write port and a registered read.
// Each request passes EXEC and then RESP, where its result is loaded into the output
// register; an in-range read passes READ between the two, a put that scrolls SCROLL.
// During a scroll one cell is moved or blanked per cycle through the RAM port; a clear
// passes FILL, one cell written per cycle.
// Only one request is worked on at a time; a new one is taken as soon as the
// previous result sits in the output register, even while out_rsp is stalled.
// A stalled receiver holds the result and stops the block after one more request.
// After reset a clearing pass writes every cell blank with attribute 0x0F and homes
// the cursor; in_req.ready stays low during it.
module text_console_writer (
  input logic       clk,
  input logic       rst_n,
  tcw_in_if.sink    in_req,
  tcw_out_if.source out_rsp,
  tcw_cfg_if.sink   cfg_wr
);

  tcw_pkg::state_t state_r, state_nxt;
  tcw_pkg::addr_t  idx_r, idx_nxt;
  tcw_pkg::col_t   col_r, col_nxt;
  tcw_pkg::row_t   row_r, row_nxt;
  tcw_pkg::attr_t  attr_r;
  tcw_pkg::cell_t  data_r, data_nxt;

  logic [tcw_pkg::OP_W-1:0]     op_r;
  tcw_pkg::code_t               code_r;
  logic [tcw_pkg::IN_ROW_W-1:0] crow_r;
  logic [tcw_pkg::IN_COL_W-1:0] ccol_r;

  // Delayed write stage of the scroll copy.
  logic           sc_wv_r, sc_wv_nxt;
  tcw_pkg::addr_t sc_wa_r, sc_wa_nxt;
  logic           sc_cp_r, sc_cp_nxt;

  logic           out_valid_r, out_valid_nxt;
  tcw_pkg::pos_t  out_pos_r, out_pos_nxt;
  tcw_pkg::cell_t out_data_r, out_data_nxt;

  logic           ram_we;
  tcw_pkg::addr_t ram_waddr;
  tcw_pkg::cell_t ram_wdata;
  tcw_pkg::addr_t ram_raddr;
  tcw_pkg::cell_t ram_rdata;

  tcw_pkg::put_res_t put_res;
  tcw_pkg::cell_t    blank;
  logic              in_acc;
  logic              idx_last;
  logic              rd_in_range;
  logic              resp_go;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor u_cursor (
    .col  (col_r),
    .row  (row_r),
    .code (code_r),
    .res  (put_res)
  );

  assign in_req.ready = (state_r == tcw_pkg::ST_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign cfg_wr.ready = 1'b1;

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.cursor_pos = out_pos_r;
  assign out_rsp.cell_data  = out_data_r;

  assign blank       = {attr_r, tcw_pkg::CH_SPACE};
  assign idx_last    = (idx_r == tcw_pkg::addr_t'(tcw_pkg::CELL_COUNT - 1));
  assign rd_in_range = (32'(crow_r) < tcw_pkg::ROWS) && (32'(ccol_r) < tcw_pkg::COLUMNS);
  assign resp_go     = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    data_nxt  = data_r;
    sc_wv_nxt = 1'b0;
    sc_wa_nxt = idx_r;
    sc_cp_nxt = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = blank;
    ram_raddr = tcw_pkg::addr_t'(idx_r + tcw_pkg::addr_t'(tcw_pkg::COLUMNS));

    case (state_r)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::RESET_CELL;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = tcw_pkg::ST_EXEC;
        end
      end
      tcw_pkg::ST_EXEC: begin
        data_nxt = '0;
        case (op_r)
          tcw_pkg::OP_PUT: begin
            col_nxt   = put_res.col;
            row_nxt   = put_res.row;
            ram_we    = put_res.wr;
            ram_waddr = tcw_pkg::cell_index(row_r, col_r);
            ram_wdata = {attr_r, code_r};
            idx_nxt   = '0;
            state_nxt = put_res.scroll ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_RESP;
          end
          tcw_pkg::OP_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = tcw_pkg::ST_FILL;
          end
          tcw_pkg::OP_READ: begin
            ram_raddr = tcw_pkg::cell_index(tcw_pkg::row_t'(crow_r), tcw_pkg::col_t'(ccol_r));
            state_nxt = rd_in_range ? tcw_pkg::ST_READ : tcw_pkg::ST_RESP;
          end
          default: begin
            state_nxt = tcw_pkg::ST_RESP;
          end
        endcase
      end
      tcw_pkg::ST_READ: begin
        data_nxt  = ram_rdata;
        state_nxt = tcw_pkg::ST_RESP;
      end
      tcw_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = tcw_pkg::ST_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // Read the cell one row below now; it is written in the next cycle (a blank in the last row).
        sc_wv_nxt = 1'b1;
        sc_cp_nxt = (32'(idx_r) < tcw_pkg::COPY_COUNT);
        if (idx_last) begin
          idx_nxt   = '0;
          state_nxt = tcw_pkg::ST_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      tcw_pkg::ST_RESP: begin
        if (resp_go) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase

    if (sc_wv_r) begin
      ram_we    = 1'b1;
      ram_waddr = sc_wa_r;
      ram_wdata = sc_cp_r ? ram_rdata : blank;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_pos_nxt   = out_pos_r;
    out_data_nxt  = out_data_r;
    if ((state_r == tcw_pkg::ST_RESP) && resp_go) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = tcw_pkg::pos_t'(tcw_pkg::cell_index(row_r, col_r));
      out_data_nxt  = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= tcw_pkg::RESET_ATTR;
      sc_wv_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      sc_wv_r     <= sc_wv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        attr_r <= cfg_wr.text_attribute;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    sc_wa_r    <= sc_wa_nxt;
    sc_cp_r    <= sc_cp_nxt;
    out_pos_r  <= out_pos_nxt;
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      op_r   <= in_req.operation;
      code_r <= in_req.char_code;
      crow_r <= in_req.cell_row;
      ccol_r <= in_req.cell_col;
    end
  end

endmodule

### hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/tcw_cursor.sv
// Cursor update for one put-character request: control codes, wrap and scroll.
module tcw_cursor (
  input  tcw_pkg::col_t     col,
  input  tcw_pkg::row_t     row,
  input  tcw_pkg::code_t    code,
  output tcw_pkg::put_res_t res
);

  // One extra bit so that a tab or an advance past the last column stays visible.
  logic [tcw_pkg::COL_W:0] colx;
  logic [tcw_pkg::COL_W:0] colx_new;
  logic [tcw_pkg::ROW_W:0] rowx_new;
  logic                    row_adv;
  logic                    wr;

  always_comb begin
    colx     = {1'b0, col};
    colx_new = colx;
    row_adv  = 1'b0;
    wr       = 1'b0;
    case (code)
      tcw_pkg::CH_BS: begin
        if (col != '0) begin
          colx_new = colx - 1'b1;
        end
      end
      tcw_pkg::CH_TAB: begin
        colx_new = (colx + (tcw_pkg::COL_W+1)'(tcw_pkg::TAB_STOP))
                   & ~(tcw_pkg::COL_W+1)'(tcw_pkg::TAB_STOP - 1);
      end
      tcw_pkg::CH_CR: begin
        colx_new = '0;
      end
      tcw_pkg::CH_LF: begin
        colx_new = '0;
        row_adv  = 1'b1;
      end
      default: begin
        if (code >= tcw_pkg::CH_SPACE) begin
          wr       = 1'b1;
          colx_new = colx + 1'b1;
        end
      end
    endcase

    if (32'(colx_new) >= tcw_pkg::COLUMNS) begin
      colx_new = '0;
      row_adv  = 1'b1;
    end

    rowx_new = {1'b0, row} + (tcw_pkg::ROW_W+1)'(row_adv);

    res.wr  = wr;
    res.col = colx_new[tcw_pkg::COL_W-1:0];
    if (32'(rowx_new) >= tcw_pkg::ROWS) begin
      res.scroll = 1'b1;
      res.row    = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
    end else begin
      res.scroll = 1'b0;
      res.row    = rowx_new[tcw_pkg::ROW_W-1:0];
    end
  end

endmodule

### hdl/tcw_checker.sv
// Port-level checks for the text console writer, bound to the top level.
module tcw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tcw_pkg::POS_W-1:0]  out_pos,
  input logic [tcw_pkg::CELL_W-1:0] out_data
);

  // Requests taken whose results have not yet been delivered.
  logic [1:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_init_blocks_requests: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken right after reset");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending request");

  a_pending_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 2'd2) |-> !in_ready)
    else $error("more than two requests in flight");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_pos) < tcw_pkg::CELL_COUNT)
    else $error("cursor position beyond the screen");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos) && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_pos   (out_rsp.cursor_pos),
  .out_data  (out_rsp.cell_data)
);

### tb/text_console_writer_tb.sv
// Self-checking testbench for the text console writer: directed and random requests.
`timescale 1ns / 100ps

module text_console_writer_tb;

  typedef logic [tcw_pkg::OP_W-1:0]     op_bits_t;
  typedef logic [tcw_pkg::IN_ROW_W-1:0] in_row_t;
  typedef logic [tcw_pkg::IN_COL_W-1:0] in_col_t;

  localparam op_bits_t       OP_UNUSED = 2'd3;
  localparam tcw_pkg::code_t CH_NUL    = 8'h00;
  localparam tcw_pkg::code_t CH_US     = 8'h1F;
  localparam tcw_pkg::code_t CODE_MAX  = 8'hFF;
  localparam tcw_pkg::attr_t ATTR_MIN  = 8'h00;
  localparam tcw_pkg::attr_t ATTR_MAX  = 8'hFF;

  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 10000;

  typedef struct {
    tcw_pkg::pos_t  pos;
    tcw_pkg::cell_t data;
  } console_result_t;

  logic clk;
  logic rst_n;

  tcw_in_if  in_req();
  tcw_out_if out_rsp();
  tcw_cfg_if cfg_wr();

  text_console_writer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  // Mirror of the console contents and cursor.
  tcw_pkg::cell_t screen_model [tcw_pkg::CELL_COUNT];
  int             cursor_col_model;
  int             cursor_row_model;
  tcw_pkg::attr_t attr_model;

  console_result_t pending_results[$];
  int mismatch_count;
  int quiet_cycles;
  int stall_left;
  bit idle_on;

  always #1 clk = ~clk;

  function automatic void console_predict(input op_bits_t op, input tcw_pkg::code_t code,
                                          input in_row_t row,
                                          input in_col_t col,
                                          output console_result_t res);
    res.data = '0;
    if (op == tcw_pkg::OP_PUT) begin
      if (code == tcw_pkg::CH_BS) begin
        if (cursor_col_model != 0) cursor_col_model--;
      end else if (code == tcw_pkg::CH_TAB) begin
        cursor_col_model = (cursor_col_model + tcw_pkg::TAB_STOP) & ~(tcw_pkg::TAB_STOP - 1);
      end else if (code == tcw_pkg::CH_CR) begin
        cursor_col_model = 0;
      end else if (code == tcw_pkg::CH_LF) begin
        cursor_col_model = 0;
        cursor_row_model++;
      end else if (code >= tcw_pkg::CH_SPACE) begin
        screen_model[cursor_row_model * tcw_pkg::COLUMNS + cursor_col_model] =
          {attr_model, code};
        cursor_col_model++;
      end
      if (cursor_col_model >= tcw_pkg::COLUMNS) begin
        cursor_col_model = 0;
        cursor_row_model++;
      end
      // Running off the bottom moves every line up and blanks the last one.
      if (cursor_row_model >= tcw_pkg::ROWS) begin
        for (int i = 0; i < tcw_pkg::COPY_COUNT; i++) begin
          screen_model[i] = screen_model[i + tcw_pkg::COLUMNS];
        end
        for (int i = tcw_pkg::COPY_COUNT; i < tcw_pkg::CELL_COUNT; i++) begin
          screen_model[i] = {attr_model, tcw_pkg::CH_SPACE};
        end
        cursor_row_model = tcw_pkg::ROWS - 1;
      end
    end else if (op == tcw_pkg::OP_CLEAR) begin
      for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) begin
        screen_model[i] = {attr_model, tcw_pkg::CH_SPACE};
      end
      cursor_col_model = 0;
      cursor_row_model = 0;
    end else if (op == tcw_pkg::OP_READ) begin
      if (row < tcw_pkg::ROWS && col < tcw_pkg::COLUMNS) begin
        res.data = screen_model[row * tcw_pkg::COLUMNS + col];
      end
    end
    res.pos = tcw_pkg::pos_t'(cursor_row_model * tcw_pkg::COLUMNS + cursor_col_model);
  endfunction

  task automatic send_request(input op_bits_t op, input tcw_pkg::code_t code,
                              input in_row_t row,
                              input in_col_t col);
    console_result_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.operation <= op;
    in_req.char_code <= code;
    in_req.cell_row  <= row;
    in_req.cell_col  <= col;
    @(posedge clk);
    while (in_req.ready !== 1'b1) @(posedge clk);
    console_predict(op, code, row, col, want);
    pending_results.push_back(want);
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The attribute may only change while no request is in flight.
  task automatic set_attribute(input tcw_pkg::attr_t value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr.valid          <= 1'b1;
    cfg_wr.text_attribute <= value;
    @(posedge clk);
    while (cfg_wr.ready !== 1'b1) @(posedge clk);
    attr_model = value;
    cfg_wr.valid <= 1'b0;
  endtask

  // Mostly text with line controls, plus reads, the unused operation and rare clears.
  task automatic send_random_mix(input int count);
    int             pick;
    tcw_pkg::code_t any_code;
    in_row_t        any_row;
    in_col_t        any_col;
    for (int i = 0; i < count; i++) begin
      pick     = $urandom_range(0, 999);
      any_code = tcw_pkg::code_t'($urandom);
      any_row  = in_row_t'($urandom);
      any_col  = in_col_t'($urandom);
      if (pick < 600) begin
        send_request(tcw_pkg::OP_PUT,
                     tcw_pkg::code_t'($urandom_range(tcw_pkg::CH_SPACE, CODE_MAX)),
                     any_row, any_col);
      end else if (pick < 680) begin
        send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, any_row, any_col);
      end else if (pick < 710) begin
        send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_CR, any_row, any_col);
      end else if (pick < 740) begin
        send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, any_row, any_col);
      end else if (pick < 780) begin
        send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, any_row, any_col);
      end else if (pick < 810) begin
        send_request(tcw_pkg::OP_PUT, tcw_pkg::code_t'($urandom_range(CH_NUL, CH_US)),
                     any_row, any_col);
      end else if (pick < 950) begin
        if ($urandom_range(0, 7) != 0) begin
          any_row = in_row_t'($urandom_range(0, tcw_pkg::ROWS - 1));
          any_col = in_col_t'($urandom_range(0, tcw_pkg::COLUMNS - 1));
        end
        send_request(tcw_pkg::OP_READ, any_code, any_row, any_col);
      end else if (pick < 970) begin
        send_request(OP_UNUSED, any_code, any_row, any_col);
      end else if (pick < 973) begin
        send_request(tcw_pkg::OP_CLEAR, any_code, any_row, any_col);
      end else begin
        send_request(tcw_pkg::OP_PUT, any_code, any_row, any_col);
      end
    end
  endtask

  task automatic test_reset_contents();
    send_request(tcw_pkg::OP_READ, CH_NUL, '0, '0);
    send_request(tcw_pkg::OP_READ, CODE_MAX, in_row_t'(tcw_pkg::ROWS - 1),
                 in_col_t'(tcw_pkg::COLUMNS - 1));
  endtask

  task automatic test_put_controls();
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_SPACE, '0, '0);
    send_request(tcw_pkg::OP_PUT, CODE_MAX, '1, '1);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, '0, '0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_CR, '0, '0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, '0, '0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, '0, '0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, '0, '0);
    send_request(tcw_pkg::OP_PUT, CH_NUL, '0, '0);
    send_request(tcw_pkg::OP_PUT, CH_US, '0, '0);
    send_request(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, '0, '0);
    send_request(tcw_pkg::OP_READ, CH_NUL, '0, '0);
    send_request(tcw_pkg::OP_READ, CH_NUL, '0, in_col_t'(1));
  endtask

  task automatic test_read_range_and_clear();
    set_attribute(ATTR_MIN);
    send_request(tcw_pkg::OP_READ, CH_NUL, in_row_t'(tcw_pkg::ROWS - 1),
                 in_col_t'(tcw_pkg::COLUMNS));
    send_request(tcw_pkg::OP_READ, CH_NUL, in_row_t'(tcw_pkg::ROWS), '0);
    send_request(tcw_pkg::OP_READ, CODE_MAX, '1, '1);
    send_request(OP_UNUSED, CODE_MAX, '1, '1);
    send_request(tcw_pkg::OP_CLEAR, CH_NUL, '0, '0);
    send_request(tcw_pkg::OP_READ, CH_NUL, '0, '0);
  endtask

  task automatic test_text_stream();
    set_attribute(ATTR_MAX);
    send_random_mix(330);
    set_attribute(tcw_pkg::attr_t'($urandom));
    send_random_mix(330);
    set_attribute(tcw_pkg::RESET_ATTR);
    send_random_mix(330);
    set_attribute(tcw_pkg::attr_t'($urandom));
    send_random_mix(330);
  endtask

  task automatic test_back_to_back();
    set_attribute(tcw_pkg::attr_t'($urandom));
    idle_on = 1'b0;
    send_random_mix(250);
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (!rst_n) begin
      stall_left = 0;
      out_rsp.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) out_rsp.ready <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 3);
      out_rsp.ready <= 1'b0;
    end
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: cursor_pos %0d cell_data %h",
               out_rsp.cursor_pos, out_rsp.cell_data);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.cursor_pos !== want.pos) begin
          $error("cursor_pos expected %0d actual %0d", want.pos, out_rsp.cursor_pos);
          mismatch_count++;
        end
        if (out_rsp.cell_data !== want.data) begin
          $error("cell_data expected %h actual %h", want.data, out_rsp.cell_data);
          mismatch_count++;
        end
      end
    end
  end

  // Scroll and clear each keep the block busy while every cell is rewritten.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[text_console_writer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    in_req.valid          = 1'b0;
    in_req.operation      = tcw_pkg::OP_PUT;
    in_req.char_code      = CH_NUL;
    in_req.cell_row       = '0;
    in_req.cell_col       = '0;
    cfg_wr.valid          = 1'b0;
    cfg_wr.text_attribute = tcw_pkg::RESET_ATTR;
    idle_on               = 1'b1;
    attr_model            = tcw_pkg::RESET_ATTR;
    cursor_col_model      = 0;
    cursor_row_model      = 0;
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) screen_model[i] = tcw_pkg::RESET_CELL;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_put_controls();
    test_read_range_and_clear();
    test_text_stream();
    test_back_to_back();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[text_console_writer] OK");
    end else begin
      $display("[text_console_writer] ERROR");
    end
    $finish;
  end

endmodule
